// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse feature extractor package
// Shared widths, the pulse record passed from the front end to the back end,
// status structs and the baseline window helper.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES) + 1;
  localparam int CFG_W       = 11;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W - 1;
  localparam int FRAC_BITS   = 8;
  localparam int DIVD_W      = SUM_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIVD_W);
  localparam int BASE_W      = 20;
  localparam int AREA_W      = 31;
  localparam int PROD_W      = DIVD_W + CNT_W;
  localparam int TRAP_W      = DIVD_W + 2;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef struct packed {
    logic [SUM_W-1:0]       bsum;
    logic [SUM_W-1:0]       tsum;
    logic [SAMPLE_BITS-1:0] first_s;
    logic [SAMPLE_BITS-1:0] last_s;
    logic [SAMPLE_BITS-1:0] min_s;
    logic [CNT_W-1:0]       count;
    logic [CFG_W-1:0]       win;
    logic                   short_p;
  } pulse_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Baseline window length; register values below two act as two.
  function automatic logic [CFG_W-1:0] win_len(input logic [CFG_W-1:0] p);
    logic [CFG_W-1:0] w;
    w = (p < CFG_W'(2)) ? CFG_W'(1) : p - CFG_W'(1);
    return w;
  endfunction

endpackage

// ===== rtl/pba_if.sv =====
// ----------------------------------------------------------------------------
// Pulse feature extractor channels
// Valid/ready channels for samples, results and the window register write.
// ----------------------------------------------------------------------------
interface pba_in_if;
  import pba_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface pba_out_if;
  import pba_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BASE_W-1:0]        baseline;
  logic signed [AREA_W-1:0] area;
  logic [BASE_W-1:0]        amplitude;
  logic                     short_pulse;
  modport source (output valid, baseline, area, amplitude, short_pulse, input ready);
  modport sink (input valid, baseline, area, amplitude, short_pulse, output ready);
endinterface

interface pba_cfg_if;
  import pba_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/pulse_baseline_area_amplitude.sv =====
// ----------------------------------------------------------------------------
// Pulse baseline, area and amplitude extractor
// Accepts one sample per cycle while the pulse queue is not full; the baseline
// comes from a 30-step bit-serial divider.
// Two closed pulses queue; while the queue is full the sample channel stalls
// until the back end takes a record from it.
// Synchronous active-high reset clears the accumulators, queue and result
// valid flag and sets the pre-trigger count to 16.
// ----------------------------------------------------------------------------
module pulse_baseline_area_amplitude (
  input  logic       clk,
  input  logic       rst,
  pba_in_if.sink     samples,
  pba_cfg_if.sink    cfg,
  pba_out_if.source  results
);
  import pba_pkg::*;

  fifo_stat_t        fstat;
  logic              push;
  logic              pop;
  pulse_rec_t        wr_rec;
  pulse_rec_t        rd_rec;
  div_stat_t         dstat;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [CFG_W-1:0]  div_divisor;
  logic [DIVD_W-1:0] div_quotient;

  pba_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .cfg     (cfg),
    .fstat   (fstat),
    .push    (push),
    .rec     (wr_rec)
  );

  pba_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .stat   (fstat)
  );

  pba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (dstat),
    .quotient (div_quotient)
  );

  pba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (rd_rec),
    .fstat        (fstat),
    .pop          (pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .dstat        (dstat),
    .div_quotient (div_quotient),
    .results      (results)
  );

endmodule

// ===== rtl/pba_front.sv =====
// ----------------------------------------------------------------------------
// Pulse accumulator front end
// Takes one sample per beat, keeps the running sums, first and minimum
// sample, and pushes a pulse record into the queue when the pulse closes.
// ----------------------------------------------------------------------------
module pba_front (
  input  logic                clk,
  input  logic                rst,
  pba_in_if.sink              samples,
  pba_cfg_if.sink             cfg,
  input  pba_pkg::fifo_stat_t fstat,
  output logic                push,
  output pba_pkg::pulse_rec_t rec
);
  import pba_pkg::*;

  logic [CFG_W-1:0]       pre_trig;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       bsum;
  logic [SUM_W-1:0]       tsum;
  logic [SAMPLE_BITS-1:0] first_s;
  logic [SAMPLE_BITS-1:0] min_s;

  logic [CFG_W-1:0]       win;
  logic [CNT_W-1:0]       count_next;
  logic [SUM_W-1:0]       bsum_next;
  logic [SUM_W-1:0]       tsum_next;
  logic [SAMPLE_BITS-1:0] first_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic                   accept;
  logic                   close;

  assign samples.ready = !fstat.full;
  assign cfg.ready     = 1'b1;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    win        = win_len(pre_trig);
    count_next = count + CNT_W'(1);
    bsum_next  = (count < win) ? bsum + SUM_W'(samples.sample) : bsum;
    tsum_next  = tsum + SUM_W'(samples.sample);
    first_next = (count == '0) ? samples.sample : first_s;
    min_next   = (samples.sample < min_s) ? samples.sample : min_s;
    close      = samples.last || (count_next == CNT_W'(MAX_SAMPLES));
  end

  always_comb begin
    rec.bsum    = bsum_next;
    rec.tsum    = tsum_next;
    rec.first_s = first_next;
    rec.last_s  = samples.sample;
    rec.min_s   = min_next;
    rec.count   = count_next;
    rec.win     = win;
    rec.short_p = (count_next < CNT_W'(2)) || (count_next < win);
    push        = accept && close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_trig <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      pre_trig <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      bsum    <= '0;
      tsum    <= '0;
      first_s <= '0;
      min_s   <= '1;
    end else if (accept) begin
      if (close) begin
        count   <= '0;
        bsum    <= '0;
        tsum    <= '0;
        first_s <= '0;
        min_s   <= '1;
      end else begin
        count   <= count_next;
        bsum    <= bsum_next;
        tsum    <= tsum_next;
        first_s <= first_next;
        min_s   <= min_next;
      end
    end
  end

endmodule

// ===== rtl/pba_fifo.sv =====
// ----------------------------------------------------------------------------
// Pulse record queue
// Short queue of closed pulse records between the front and back ends.
// ----------------------------------------------------------------------------
module pba_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pba_pkg::pulse_rec_t wr_rec,
  input  logic                pop,
  output pba_pkg::pulse_rec_t rd_rec,
  output pba_pkg::fifo_stat_t stat
);
  import pba_pkg::*;

  pulse_rec_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     fill;

  assign stat.full  = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_rec     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (FIFO_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("pulse record pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("pulse record popped from an empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== rtl/pba_div.sv =====
// ----------------------------------------------------------------------------
// Baseline divider
// Restoring divider, one quotient bit per cycle, for the scaled baseline sum
// over the window length.
// ----------------------------------------------------------------------------
module pba_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pba_pkg::DIVD_W-1:0]       dividend,
  input  logic [pba_pkg::CFG_W-1:0]        divisor,
  output pba_pkg::div_stat_t               stat,
  output logic [pba_pkg::DIVD_W-1:0]       quotient
);
  import pba_pkg::*;

  logic [DIVD_W-1:0]    q;
  logic [CFG_W-1:0]     rem;
  logic [CFG_W-1:0]     divs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [CFG_W:0]       trial;
  logic                 qbit;
  logic [CFG_W-1:0]     rem_next;

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

  always_comb begin
    trial    = {rem, q[DIVD_W-1]};
    qbit     = (trial >= {1'b0, divs});
    rem_next = qbit ? CFG_W'(trial - {1'b0, divs}) : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= dividend;
      rem  <= '0;
      divs <= divisor;
      cnt  <= DIV_CNT_W'(DIVD_W-1);
    end else if (busy) begin
      q   <= {q[DIVD_W-2:0], qbit};
      rem <= rem_next;
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

// ===== rtl/pba_back.sv =====
// ----------------------------------------------------------------------------
// Pulse result back end
// Pops pulse records, divides for the baseline, then forms the area and
// amplitude with saturation and holds the result in the output register.
// ----------------------------------------------------------------------------
module pba_back (
  input  logic                         clk,
  input  logic                         rst,
  input  pba_pkg::pulse_rec_t          head,
  input  pba_pkg::fifo_stat_t          fstat,
  output logic                         pop,
  output logic                         div_start,
  output logic [pba_pkg::DIVD_W-1:0]   div_dividend,
  output logic [pba_pkg::CFG_W-1:0]    div_divisor,
  input  pba_pkg::div_stat_t           dstat,
  input  logic [pba_pkg::DIVD_W-1:0]   div_quotient,
  pba_out_if.source                    results
);
  import pba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int DIFF_W = PROD_W + 2;
  localparam logic signed [DIFF_W-1:0] AREA_HI = DIFF_W'(2**(AREA_W-1) - 1);
  localparam logic signed [DIFF_W-1:0] AREA_LO = DIFF_W'(-(2**(AREA_W-1)));

  logic [1:0]               state;
  logic [1:0]               state_next;
  pulse_rec_t               rec;
  logic [DIVD_W-1:0]        base_q;
  logic [PROD_W-1:0]        prod;
  logic signed [TRAP_W-1:0] trap;
  logic                     out_valid;
  logic [BASE_W-1:0]        out_base;
  logic signed [AREA_W-1:0] out_area;
  logic [BASE_W-1:0]        out_amp;
  logic                     out_short;

  logic [SAMPLE_BITS:0]     edge_sum;
  logic signed [DIFF_W-1:0] diff;
  logic [AREA_W-1:0]        area_sat;
  logic [DIVD_W-1:0]        min_scaled;
  logic [DIVD_W-1:0]        amp_full;
  logic [BASE_W-1:0]        amp_sat;
  logic [BASE_W-1:0]        base_sat;
  logic                     load;

  assign pop          = (state == S_IDLE) && !fstat.empty;
  assign div_start    = pop;
  assign div_dividend = {head.bsum, FRAC_BITS'(0)};
  assign div_divisor  = head.win;
  assign load         = (state == S_FIN) && (!out_valid || results.ready);

  assign results.valid       = out_valid;
  assign results.baseline    = out_base;
  assign results.area        = out_area;
  assign results.amplitude   = out_amp;
  assign results.short_pulse = out_short;

  always_comb begin
    edge_sum   = (SAMPLE_BITS+1)'(rec.first_s) + (SAMPLE_BITS+1)'(rec.last_s);
    diff       = DIFF_W'(trap) - $signed({2'b00, prod});
    if (diff > AREA_HI) begin
      area_sat = AREA_HI[AREA_W-1:0];
    end else if (diff < AREA_LO) begin
      area_sat = AREA_LO[AREA_W-1:0];
    end else begin
      area_sat = diff[AREA_W-1:0];
    end
    min_scaled = DIVD_W'({rec.min_s, FRAC_BITS'(0)});
    amp_full   = (base_q > min_scaled) ? base_q - min_scaled : '0;
    amp_sat    = (|amp_full[DIVD_W-1:BASE_W]) ? '1 : amp_full[BASE_W-1:0];
    base_sat   = (|base_q[DIVD_W-1:BASE_W]) ? '1 : base_q[BASE_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (dstat.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= head;
    end
    if ((state == S_DIV) && dstat.done) begin
      base_q <= div_quotient;
    end
    if (state == S_MUL) begin
      prod <= base_q * (rec.count - CNT_W'(1));
      trap <= $signed({2'b00, rec.tsum, FRAC_BITS'(0)})
            - $signed(TRAP_W'({edge_sum, (FRAC_BITS-1)'(0)}));
    end
    if (load) begin
      out_short <= rec.short_p;
      out_base  <= rec.short_p ? '0 : base_sat;
      out_area  <= rec.short_p ? '0 : $signed(area_sat);
      out_amp   <= rec.short_p ? '0 : amp_sat;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> out_valid && $stable(out_area) && $stable(out_base))
    else $error("stalled result changed");

endmodule
